// File: hw/rtl/quaternion_to_euler_macros.svh
// Assertion macros for the quaternion to Euler angle converter.
// Used by the checker module; no other dependencies.
`ifndef QUATERNION_TO_EULER_MACROS_SVH
`define QUATERNION_TO_EULER_MACROS_SVH

// Check a property while out of reset.
`define QTE_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("quaternion_to_euler: assertion failed");

// Check a property at every edge, reset included.
`define QTE_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("quaternion_to_euler: reset assertion failed");

`endif

// File: hw/rtl/qte_pkg.sv
// Shared types, constants and the arctangent table of the quaternion to Euler converter.
// No dependencies.
`default_nettype none
package qte_pkg;
  localparam int OPW   = 36;
  localparam int CW    = 38;
  localparam int ZW    = 34;
  localparam int VW    = 58;
  localparam int RW    = 31;
  localparam int QW    = 29;
  localparam int NSQ   = 29;
  localparam int MAGW  = 31;
  localparam int SQW   = 62;
  localparam int THRW  = 29;
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int RND_SH   = 17;
  localparam int RND_BIAS = 65536;

  localparam logic signed [OPW-1:0]  ONE_Q28     = 36'sd268435456;
  localparam logic [SQW-1:0]         SQ_ONE      = 62'd72057594037927936;
  localparam logic signed [ZW-1:0]   ANG_HALF_PI = 34'sd1686629713;
  localparam logic signed [ZW-RND_SH:0] OUT_PI      = 18'sd25736;
  localparam logic signed [ZW-RND_SH:0] OUT_HALF_PI = 18'sd12868;
  localparam logic [THRW-1:0]        THR_RESET   = 29'd134217594;
  localparam logic                   REG_THR     = 1'b0;

  typedef struct packed {
    logic signed [OPW-1:0] roll_y;
    logic signed [OPW-1:0] roll_x;
    logic signed [OPW-1:0] yaw_y;
    logic signed [OPW-1:0] yaw_x;
    logic signed [OPW-1:0] pitch_s;
    logic                  clamp_p;
    logic                  clamp_n;
    logic [VW-1:0]         rad;
  } qte_job_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } qte_cch_t;

  typedef struct packed {
    qte_cch_t roll;
    qte_cch_t yaw;
    qte_cch_t pitch;
    logic     clamp_p;
    logic     clamp_n;
  } qte_cst_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
    case (idx)
      5'd0:  return 34'sd843314857;
      5'd1:  return 34'sd497837829;
      5'd2:  return 34'sd263043837;
      5'd3:  return 34'sd133525159;
      5'd4:  return 34'sd67021687;
      5'd5:  return 34'sd33543516;
      5'd6:  return 34'sd16775851;
      5'd7:  return 34'sd8388437;
      5'd8:  return 34'sd4194283;
      5'd9:  return 34'sd2097149;
      5'd10: return 34'sd1048576;
      5'd11: return 34'sd524288;
      5'd12: return 34'sd262144;
      5'd13: return 34'sd131072;
      5'd14: return 34'sd65536;
      5'd15: return 34'sd32768;
      5'd16: return 34'sd16384;
      5'd17: return 34'sd8192;
      5'd18: return 34'sd4096;
      5'd19: return 34'sd2048;
      5'd20: return 34'sd1024;
      5'd21: return 34'sd512;
      5'd22: return 34'sd256;
      5'd23: return 34'sd128;
      default: return '0;
    endcase
  endfunction
endpackage
`default_nettype wire

// File: hw/rtl/qte_ifs.sv
// Valid/ready channel interfaces for quaternion items in and angle items out.
// No dependencies.
`default_nettype none
interface qte_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface qte_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  logic signed [15:0] roll_angle;
  modport source (output valid, pitch_angle, yaw_angle, roll_angle, input ready);
  modport sink   (input valid, pitch_angle, yaw_angle, roll_angle, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/qte_front.sv
// Front end: products, atan2 operands, pitch clamp classification and 1 - s*s.
// Depends on qte_pkg and qte_in_if.
`default_nettype none
module qte_front (
  input  logic                 clk,
  input  logic                 rst_n,
  qte_in_if.sink               in_ch,
  input  logic [28:0]          thr,
  input  logic                 q_full,
  output logic                 push,
  output qte_pkg::qte_job_t    job
);
  import qte_pkg::*;

  logic                   fe;
  logic [4:0]             vld_r;
  logic signed [31:0]     p_wz_r, p_xy_r, p_zz_r, p_xx_r, p_wy_r, p_xz_r, p_yy_r, p_wx_r, p_yz_r;
  qte_job_t               j2, j2_r, j3_r, j4_r, j5_r;
  qte_job_t               j3_nxt, j5_nxt;
  logic signed [OPW-1:0]  mag_s;
  logic signed [OPW-1:0]  thr2;
  logic [MAGW-1:0]        mag3_r;
  logic [SQW-1:0]         sq4_r;

  assign fe          = !(vld_r[4] && q_full);
  assign in_ch.ready = fe;
  assign push        = vld_r[4] && !q_full;
  assign job         = j5_r;
  assign thr2        = $signed({{(OPW-THRW-1){1'b0}}, thr, 1'b0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (fe) begin
      vld_r <= {vld_r[3:0], in_ch.valid};
    end
  end

  always_comb begin
    j2         = '0;
    j2.roll_y  = (OPW'(p_wz_r) + OPW'(p_xy_r)) <<< 1;
    j2.roll_x  = ONE_Q28 - ((OPW'(p_zz_r) + OPW'(p_xx_r)) <<< 1);
    j2.yaw_y   = (OPW'(p_wy_r) + OPW'(p_xz_r)) <<< 1;
    j2.yaw_x   = ONE_Q28 - ((OPW'(p_xx_r) + OPW'(p_yy_r)) <<< 1);
    j2.pitch_s = (OPW'(p_wx_r) - OPW'(p_yz_r)) <<< 1;
    mag_s      = j2_r.pitch_s[OPW-1] ? -j2_r.pitch_s : j2_r.pitch_s;
    j3_nxt         = j2_r;
    j3_nxt.clamp_p = j2_r.pitch_s > thr2;
    j3_nxt.clamp_n = j2_r.pitch_s < -thr2;
    j5_nxt         = j4_r;
    j5_nxt.rad     = (sq4_r >= SQ_ONE) ? '0 : VW'(SQ_ONE - sq4_r);
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      p_wz_r <= 32'(in_ch.quat_w) * 32'(in_ch.quat_z);
      p_xy_r <= 32'(in_ch.quat_x) * 32'(in_ch.quat_y);
      p_zz_r <= 32'(in_ch.quat_z) * 32'(in_ch.quat_z);
      p_xx_r <= 32'(in_ch.quat_x) * 32'(in_ch.quat_x);
      p_wy_r <= 32'(in_ch.quat_w) * 32'(in_ch.quat_y);
      p_xz_r <= 32'(in_ch.quat_x) * 32'(in_ch.quat_z);
      p_yy_r <= 32'(in_ch.quat_y) * 32'(in_ch.quat_y);
      p_wx_r <= 32'(in_ch.quat_w) * 32'(in_ch.quat_x);
      p_yz_r <= 32'(in_ch.quat_y) * 32'(in_ch.quat_z);
      j2_r   <= j2;
      j3_r   <= j3_nxt;
      mag3_r <= mag_s[MAGW-1:0];
      j4_r   <= j3_r;
      sq4_r  <= SQW'(mag3_r) * SQW'(mag3_r);
      j5_r   <= j5_nxt;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/qte_queue.sv
// Short item queue between the front end and the square root / CORDIC back end.
// Depends on qte_pkg.
`default_nettype none
module qte_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  qte_pkg::qte_job_t  push_job,
  output logic               full,
  input  logic               pop,
  output qte_pkg::qte_job_t  head,
  output logic               q_valid
);
  import qte_pkg::*;

  qte_job_t        mem_r [QDEPTH];
  logic [QAW-1:0]  wr_r, rd_r;
  logic [QAW:0]    cnt_r;

  assign full    = cnt_r == (QAW+1)'(QDEPTH);
  assign q_valid = cnt_r != '0;
  assign head    = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/qte_back.sv
// Back end: pipelined integer square root for the pitch cosine, three CORDIC atan2
// pipelines, rounding to Q3.13 and the output register. Depends on qte_pkg, qte_out_if.
`default_nettype none
module qte_back #(
  parameter int ITER = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  qte_pkg::qte_job_t  job,
  input  logic               q_valid,
  output logic               pop,
  qte_out_if.source          out_ch
);
  import qte_pkg::*;

  logic                   be;
  qte_job_t               sq_job_r  [NSQ];
  logic [RW-1:0]          sq_rem_r  [NSQ];
  logic [QW-1:0]          sq_root_r [NSQ];
  logic                   sq_vld_r  [NSQ];
  qte_cst_t               cr_r      [ITER+1];
  logic                   cr_vld_r  [ITER+1];
  qte_cst_t               last;
  logic signed [ZW-1:0]   pitch_z;
  logic                   out_vld_r;
  logic signed [14:0]     out_pitch_r;
  logic signed [15:0]     out_yaw_r, out_roll_r;

  function automatic qte_cch_t prerot(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
    qte_cch_t r;
    r.zero = (x == '0) && (y == '0);
    if (x < 0) begin
      if (y >= 0) begin
        r.x = y;
        r.y = -x;
        r.z = ANG_HALF_PI;
      end else begin
        r.x = -y;
        r.y = x;
        r.z = -ANG_HALF_PI;
      end
    end else begin
      r.x = x;
      r.y = y;
      r.z = '0;
    end
    return r;
  endfunction

  function automatic qte_cch_t rotate(input qte_cch_t c, input int i);
    qte_cch_t             r;
    logic signed [CW-1:0] xs, ys;
    xs = c.x >>> i;
    ys = c.y >>> i;
    r  = c;
    if (!c.y[CW-1]) begin
      r.x = c.x + ys;
      r.y = c.y - xs;
      r.z = c.z + atan_q30(5'(i));
    end else begin
      r.x = c.x - ys;
      r.y = c.y + xs;
      r.z = c.z - atan_q30(5'(i));
    end
    return r;
  endfunction

  function automatic logic signed [ZW-RND_SH:0] rnd(input logic signed [ZW-1:0] z,
                                                    input logic signed [ZW-RND_SH:0] lim);
    logic signed [ZW:0]        sm;
    logic signed [ZW-RND_SH:0] q;
    sm = (ZW+1)'(z) + (ZW+1)'(RND_BIAS);
    q  = $signed(sm[ZW:RND_SH]);
    if (q > lim) begin
      q = lim;
    end
    if (q < -lim) begin
      q = -lim;
    end
    return q;
  endfunction

  assign be  = !out_vld_r || out_ch.ready;
  assign pop = be && q_valid;

  for (genvar k = 0; k < NSQ; k++) begin : g_sq
    qte_job_t        src_job;
    qte_job_t        sq_job_nxt;
    logic [RW-1:0]   src_rem;
    logic [QW-1:0]   src_root;
    logic            src_vld;
    logic [RW+1:0]   rem2, trial;
    logic            ge;
    if (k == 0) begin : g_first
      assign src_job  = job;
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_vld  = q_valid;
    end else begin : g_next
      assign src_job  = sq_job_r[k-1];
      assign src_rem  = sq_rem_r[k-1];
      assign src_root = sq_root_r[k-1];
      assign src_vld  = sq_vld_r[k-1];
    end
    assign rem2  = {src_rem, src_job.rad[VW-1 -: 2]};
    assign trial = (RW+2)'({src_root, 2'b01});
    assign ge    = rem2 >= trial;

    always_comb begin
      sq_job_nxt     = src_job;
      sq_job_nxt.rad = src_job.rad << 2;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k] <= 1'b0;
      end else if (be) begin
        sq_vld_r[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (be) begin
        sq_rem_r[k]  <= ge ? RW'(rem2 - trial) : RW'(rem2);
        sq_root_r[k] <= {src_root[QW-2:0], ge};
        sq_job_r[k]  <= sq_job_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cr_vld_r[0] <= 1'b0;
    end else if (be) begin
      cr_vld_r[0] <= sq_vld_r[NSQ-1];
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      cr_r[0].roll    <= prerot(CW'(sq_job_r[NSQ-1].roll_x), CW'(sq_job_r[NSQ-1].roll_y));
      cr_r[0].yaw     <= prerot(CW'(sq_job_r[NSQ-1].yaw_x), CW'(sq_job_r[NSQ-1].yaw_y));
      cr_r[0].pitch   <= prerot($signed({{(CW-QW){1'b0}}, sq_root_r[NSQ-1]}),
                                CW'(sq_job_r[NSQ-1].pitch_s));
      cr_r[0].clamp_p <= sq_job_r[NSQ-1].clamp_p;
      cr_r[0].clamp_n <= sq_job_r[NSQ-1].clamp_n;
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_cr
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cr_vld_r[i+1] <= 1'b0;
      end else if (be) begin
        cr_vld_r[i+1] <= cr_vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (be) begin
        cr_r[i+1].roll    <= rotate(cr_r[i].roll, i);
        cr_r[i+1].yaw     <= rotate(cr_r[i].yaw, i);
        cr_r[i+1].pitch   <= rotate(cr_r[i].pitch, i);
        cr_r[i+1].clamp_p <= cr_r[i].clamp_p;
        cr_r[i+1].clamp_n <= cr_r[i].clamp_n;
      end
    end
  end

  always_comb begin
    last = cr_r[ITER];
    if (last.clamp_n) begin
      pitch_z = -ANG_HALF_PI;
    end else if (last.clamp_p) begin
      pitch_z = ANG_HALF_PI;
    end else if (last.pitch.zero) begin
      pitch_z = '0;
    end else begin
      pitch_z = last.pitch.z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (be) begin
      out_vld_r <= cr_vld_r[ITER];
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      out_pitch_r <= 15'(rnd(pitch_z, OUT_HALF_PI));
      out_yaw_r   <= 16'(rnd(last.yaw.zero ? '0 : last.yaw.z, OUT_PI));
      out_roll_r  <= 16'(rnd(last.roll.zero ? '0 : last.roll.z, OUT_PI));
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.pitch_angle = out_pitch_r;
  assign out_ch.yaw_angle   = out_yaw_r;
  assign out_ch.roll_angle  = out_roll_r;
endmodule
`default_nettype wire

// File: hw/rtl/quaternion_to_euler.sv
// Quaternion to Euler angles (5 front stages, queue, 29 square root stages,
// pre-rotation, CORDIC, output register). Throughput one item per cycle while
// out_ch.ready does not hold the output; every stage is a pipeline register.
// Reset (synchronous, active low) empties the pipeline and queue and loads the pitch
// clamp threshold with its default. Depends on qte_pkg, qte_ifs, qte_front/queue/back.
`default_nettype none
module quaternion_to_euler #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  qte_in_if.sink      in_ch,
  qte_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import qte_pkg::*;

  logic [THRW-1:0] thr_r;
  logic            q_full, q_push, q_pop, q_valid;
  qte_job_t        f_job, q_head;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_THR) ? {{(32-THRW){1'b0}}, thr_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && cfg_paddr[2] == REG_THR) begin
      thr_r <= cfg_pwdata[THRW-1:0];
    end
  end

  qte_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .thr    (thr_r),
    .q_full (q_full),
    .push   (q_push),
    .job    (f_job)
  );

  qte_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (f_job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .q_valid  (q_valid)
  );

  qte_back #(
    .ITER (CORDIC_ITERATIONS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .job     (q_head),
    .q_valid (q_valid),
    .pop     (q_pop),
    .out_ch  (out_ch)
  );
endmodule
`default_nettype wire

// File: hw/rtl/qte_checker.sv
// Port-level checks on the quaternion to Euler converter, bound to the top level.
// Depends on quaternion_to_euler_macros.svh.
`default_nettype none
`include "quaternion_to_euler_macros.svh"
module qte_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [14:0] pitch,
  input logic signed [15:0] yaw,
  input logic signed [15:0] roll
);
  `QTE_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready |=> out_valid))
  `QTE_ASSERT(a_out_stable, clk, rst_n, (out_valid && !out_ready |=> $stable(pitch) && $stable(yaw) && $stable(roll)))
  `QTE_ASSERT(a_angle_range, clk, rst_n, (out_valid |-> pitch >= -15'sd12868 && pitch <= 15'sd12868 && yaw >= -16'sd25736 && yaw <= 16'sd25736 && roll >= -16'sd25736 && roll <= 16'sd25736))
  `QTE_ASSERT_ALWAYS(a_reset_idle, clk, (!rst_n |=> !out_valid))
endmodule

bind quaternion_to_euler qte_checker u_qte_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .pitch     (out_ch.pitch_angle),
  .yaw       (out_ch.yaw_angle),
  .roll      (out_ch.roll_angle)
);
`default_nettype wire
